// ===== rtl/omc_pkg.sv =====
// omc_pkg: shared constants, codes and the sine table for the chassis velocity mixer
`default_nettype none

package omc_pkg;

    // percent scale, Q7.8 with 100 percent at 25600
    localparam int PctFull = 25600;

    // angles in 1/45 degree
    localparam int AngFull = 16200;
    localparam int AngHalf = 8100;
    localparam int AngQuad = 4050;

    // divider: quotient bits, dividend and divisor widths
    localparam int QW = 15;
    localparam int NW = 31;
    localparam int DW = 17;
    localparam int Lanes = 3;

    // register stages ahead of the output register
    localparam int PipeStages = 13 + QW;

    typedef enum logic [1:0] {
        MODE_FAIR  = 2'd0,
        MODE_TRANS = 2'd1,
        MODE_ROT   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_RPM    = 2'd1,
        REG_ORIGIN = 2'd2
    } reg_idx_t;

    // sine at 5 degree steps, Q2.14, last entry repeated so the slope there is zero
    function automatic logic [14:0] sin_tab(input logic [4:0] idx);
        logic [14:0] r;
        unique case (idx)
            5'd0:    r = 15'd0;
            5'd1:    r = 15'd1428;
            5'd2:    r = 15'd2845;
            5'd3:    r = 15'd4240;
            5'd4:    r = 15'd5604;
            5'd5:    r = 15'd6924;
            5'd6:    r = 15'd8192;
            5'd7:    r = 15'd9397;
            5'd8:    r = 15'd10531;
            5'd9:    r = 15'd11585;
            5'd10:   r = 15'd12551;
            5'd11:   r = 15'd13421;
            5'd12:   r = 15'd14189;
            5'd13:   r = 15'd14849;
            5'd14:   r = 15'd15396;
            5'd15:   r = 15'd15826;
            5'd16:   r = 15'd16135;
            5'd17:   r = 15'd16322;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/omc_if.sv =====
// omc interfaces: command, wheel result and register write channels
`default_nettype none

interface omc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] set_x;
    logic signed [15:0] set_y;
    logic signed [15:0] set_z;
    logic        [12:0] gimbal_angle;

    modport source (output valid, set_x, set_y, set_z, gimbal_angle, input ready);
    modport sink (input valid, set_x, set_y, set_z, gimbal_angle, output ready);
endinterface

interface omc_whl_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel_front_left;
    logic signed [15:0] wheel_front_right;
    logic signed [15:0] wheel_rear_left;
    logic signed [15:0] wheel_rear_right;
    logic               heading_backward;

    modport source (output valid, wheel_front_left, wheel_front_right, wheel_rear_left,
                    wheel_rear_right, heading_backward, input ready);
    modport sink (input valid, wheel_front_left, wheel_front_right, wheel_rear_left,
                  wheel_rear_right, heading_backward, output ready);
endinterface

interface omc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/omc_sin.sv =====
// omc_sin: four-stage sine of an angle in 1/45 degree, Q2.14 out
`default_nettype none

module omc_sin
    import omc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic        [13:0] angle,
    output logic signed [15:0]      sin_val
);

    logic [1:0]  quad_next;
    logic [11:0] r_next;
    logic [1:0]  quad1_reg;
    logic [11:0] r1_reg;

    logic [24:0] idx_prod;
    logic [1:0]  quad2_reg;
    logic [11:0] r2_reg;
    logic [4:0]  idx2_reg;

    logic [14:0] base_next;
    logic [14:0] top_val;
    logic [10:0] slope;
    logic [11:0] frac_wide;
    logic [7:0]  frac;
    logic [18:0] p_next;
    logic [1:0]  quad3_reg;
    logic [14:0] base3_reg;
    logic [18:0] p3_reg;

    logic [37:0] q_prod;
    logic [14:0] mag;
    logic signed [15:0] sin_next;
    logic signed [15:0] sin_reg;

    // fold into the first quadrant
    always_comb
    begin
        if (angle < 14'(AngQuad))
        begin
            quad_next = 2'd0;
            r_next    = angle[11:0];
        end
        else if (angle < 14'(AngHalf))
        begin
            quad_next = 2'd1;
            r_next    = 12'(14'(AngHalf) - angle);
        end
        else if (angle < 14'(AngHalf + AngQuad))
        begin
            quad_next = 2'd2;
            r_next    = 12'(angle - 14'(AngHalf));
        end
        else
        begin
            quad_next = 2'd3;
            r_next    = 12'(14'(AngFull) - angle);
        end
    end

    // table index is r / 225 by reciprocal
    assign idx_prod = 25'(r1_reg) * 25'd4661;

    always_comb
    begin
        base_next = sin_tab(idx2_reg);
        top_val   = sin_tab(5'(idx2_reg + 5'd1));
        slope     = 11'(top_val - base_next);
        frac_wide = r2_reg - 12'(idx2_reg * 12'd225);
        frac      = frac_wide[7:0];
        p_next    = 19'(slope) * 19'(frac) + 19'd112;
    end

    // interpolation step divided by 225 by reciprocal
    always_comb
    begin
        q_prod   = 38'(p3_reg) * 38'd298262;
        mag      = base3_reg + 15'(q_prod[36:26]);
        sin_next = quad3_reg[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg <= quad_next;
            r1_reg    <= r_next;
            quad2_reg <= quad1_reg;
            r2_reg    <= r1_reg;
            idx2_reg  <= idx_prod[24:20];
            quad3_reg <= quad2_reg;
            base3_reg <= base_next;
            p3_reg    <= p_next;
            sin_reg   <= sin_next;
        end
    end

    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// ===== rtl/omc_div.sv =====
// omc_div: three-lane restoring divider, one quotient bit per stage, shared divisor
`default_nettype none

module omc_div
    import omc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num [Lanes],
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo [Lanes]
);

    logic [NW-1:0] rem_reg [QW][Lanes];
    logic [QW-1:0] q_reg   [QW][Lanes];
    logic [DW-1:0] den_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int Bit = QW - 1 - j;

        logic [NW-1:0] rem_in [Lanes];
        logic [QW-1:0] q_in   [Lanes];
        logic [DW-1:0] den_in;
        logic [NW-1:0] dsh;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                den_in = den;
                for (int l = 0; l < Lanes; l++)
                begin
                    rem_in[l] = num[l];
                    q_in[l]   = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                den_in = den_reg[j-1];
                for (int l = 0; l < Lanes; l++)
                begin
                    rem_in[l] = rem_reg[j-1][l];
                    q_in[l]   = q_reg[j-1][l];
                end
            end
        end

        assign dsh = NW'(den_in) << Bit;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_in;
                for (int l = 0; l < Lanes; l++)
                begin
                    if (rem_in[l] >= dsh)
                    begin
                        rem_reg[j][l] <= rem_in[l] - dsh;
                        q_reg[j][l]   <= q_in[l] | (QW'(1) << Bit);
                    end
                    else
                    begin
                        rem_reg[j][l] <= rem_in[l];
                        q_reg[j][l]   <= q_in[l];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            quo[l] = q_reg[QW-1][l];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/omni_chassis_velocity_mixer.sv =====
// omni_chassis_velocity_mixer: four-wheel omni chassis inverse kinematics, top level
`default_nettype none

// Takes one command word per cycle: x, y, z speed in Q7.8 percent plus a gimbal
// yaw count (22.5 counts per degree), and returns one word of four wheel rpm
// setpoints plus a backward-heading flag, in command order. Any axis beyond
// 100 percent forces all axes to sign times 100; a backward heading negates x
// and y; x/y are rotated by the heading against origin_angle; the |x|+|y|+|z|
// budget is enforced by distribute_mode; wheels are mixed and scaled by
// wheel_rpm_max and saturated to +/-32767. From accept to the word appearing on
// the result port it passes 2 angle stages, 4 sine stages, 4 rotate and budget
// stages, 15 stages of the bit-per-stage divider, 3 rpm scaling stages and the
// output register. Throughput is one word per cycle unless the skid is full.
// A two-entry output register (output plus skid) decouples the ports, so the
// command side keeps taking words while one finished word waits; cmd.ready
// drops only once the skid entry holds a second waiting word. Registers are
// written through cfg at any time (cfg.ready is always high) but must only
// change while no word is in flight. No clearing pass after reset.

module omni_chassis_velocity_mixer
    import omc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    omc_cmd_if.sink    cmd,
    omc_whl_if.source  wheel,
    omc_cfg_if.sink    cfg
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               back;
    } axes_t;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic               div_xy;
        logic               div_z;
        logic               back;
    } side_t;

    // ---------------------------------------------------------------- registers
    logic [1:0]  mode_reg;
    logic [14:0] rpm_reg;
    logic [8:0]  origin_reg;

    // ---------------------------------------------------------------- control
    logic [PipeStages-1:0] v_reg;
    logic                  en;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  arrive;
    logic                  take;

    // ---------------------------------------------------------------- stage data
    axes_t              s0_reg;
    logic signed [16:0] araw0_reg;
    axes_t              s1_reg;
    logic [13:0]        asin1_reg;
    logic [13:0]        acos1_reg;
    axes_t              rot_reg [4];
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic signed [31:0] px6_reg;
    logic signed [31:0] py6_reg;
    logic signed [15:0] z6_reg;
    logic               back6_reg;
    logic signed [16:0] rx7_reg;
    logic signed [16:0] ry7_reg;
    logic signed [15:0] z7_reg;
    logic               back7_reg;
    side_t              side8_reg;
    logic [15:0]        ax8_reg;
    logic [15:0]        ay8_reg;
    logic [14:0]        az8_reg;
    logic [DW-1:0]      den8_reg;
    logic [14:0]        mul8_reg;
    side_t              side9_reg;
    logic [NW-1:0]      num9_reg [Lanes];
    logic [DW-1:0]      den9_reg;
    side_t              side_dv_reg [QW];
    logic [QW-1:0]      quo [Lanes];
    logic signed [18:0] w25_reg [4];
    logic               back25_reg;
    logic [32:0]        m26_reg [4];
    logic [3:0]         neg26_reg;
    logic               back26_reg;
    logic [21:0]        t27_reg [4];
    logic [3:0]         sat27_reg;
    logic [3:0]         neg27_reg;
    logic               back27_reg;

    logic signed [15:0] out_whl_reg [4];
    logic               out_back_reg;
    logic signed [15:0] skid_whl_reg [4];
    logic               skid_back_reg;

    // ---------------------------------------------------------------- next values
    axes_t              s0_next;
    logic               back_next;
    logic               over_next;
    logic [14:0]        org45;
    logic signed [16:0] araw_next;
    logic signed [16:0] awrap;
    logic [13:0]        asin_next;
    logic [14:0]        acos_sum;
    logic [13:0]        acos_next;
    axes_t              s1_next;
    logic signed [31:0] xc;
    logic signed [31:0] ys;
    logic signed [31:0] xs;
    logic signed [31:0] yc;
    logic [15:0]        ax_next;
    logic [15:0]        ay_next;
    logic [14:0]        az_next;
    logic [16:0]        xy;
    logic [16:0]        total;
    logic [14:0]        rem_trans;
    logic [14:0]        rem_rot;
    side_t              side8_next;
    logic [DW-1:0]      den_next;
    logic [14:0]        mul_next;
    logic signed [16:0] xf;
    logic signed [16:0] yf;
    logic signed [16:0] zf;
    logic signed [18:0] w_next [4];
    logic signed [15:0] whl_next [4];

    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v > 16'sd0)
            r = 16'(PctFull);
        else if (v < 16'sd0)
            r = -16'(PctFull);
        else
            r = 16'sd0;
        return r;
    endfunction

    // divide by 2^14, rounding half away from zero
    function automatic logic signed [16:0] round_q14(input logic signed [31:0] v);
        logic [31:0] m;
        logic [31:0] q;
        logic signed [16:0] r;
        m = v < 0 ? 32'(-v) : 32'(v);
        q = (m + 32'd8192) >> 14;
        r = signed'(q[16:0]);
        return v < 0 ? -r : r;
    endfunction

    function automatic logic signed [16:0] apply_sign(input logic neg, input logic [QW-1:0] q);
        logic signed [16:0] r;
        r = signed'({2'b00, q});
        return neg ? -r : r;
    endfunction

    // ---------------------------------------------------------------- config port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FAIR;
            rpm_reg    <= 15'd8000;
            origin_reg <= 9'd0;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_MODE:   mode_reg   <= cfg.data[1:0];
                REG_RPM:    rpm_reg    <= cfg.data;
                REG_ORIGIN: origin_reg <= cfg.data[8:0];
                default:    ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // the whole pipe moves while the skid entry is free
    assign en        = !skid_valid_reg;
    assign cmd.ready = en;
    assign arrive    = en && v_reg[PipeStages-1];
    assign take      = out_valid_reg && wheel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[PipeStages-2:0], cmd.valid};
            end
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (arrive)
            begin
                if (out_valid_reg && !wheel.ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- stage 0
    // heading, over-range clamp, raw heading angle
    always_comb
    begin
        back_next = (cmd.gimbal_angle > 13'd2025) && (cmd.gimbal_angle < 13'd6075);
        over_next = (cmd.set_x > 16'(PctFull)) || (cmd.set_x < -16'(PctFull)) ||
                    (cmd.set_y > 16'(PctFull)) || (cmd.set_y < -16'(PctFull)) ||
                    (cmd.set_z > 16'(PctFull)) || (cmd.set_z < -16'(PctFull));
        s0_next.x    = over_next ? clamp_axis(cmd.set_x) : cmd.set_x;
        s0_next.y    = over_next ? clamp_axis(cmd.set_y) : cmd.set_y;
        s0_next.z    = over_next ? clamp_axis(cmd.set_z) : cmd.set_z;
        s0_next.back = back_next;
        org45        = 15'(origin_reg * 15'd45);
        araw_next    = $signed({3'b000, cmd.gimbal_angle, 1'b0})
                       - (back_next ? 17'(AngHalf) : 17'sd0)
                       - $signed({2'b00, org45});
    end

    // ---------------------------------------------------------------- stage 1
    // wrap angle, cosine angle, backward negation
    always_comb
    begin
        if (araw0_reg >= 17'(AngFull))
            awrap = araw0_reg - 17'(AngFull);
        else if (araw0_reg < -17'(AngFull))
            awrap = araw0_reg + 17'(2 * AngFull);
        else if (araw0_reg < 17'sd0)
            awrap = araw0_reg + 17'(AngFull);
        else
            awrap = araw0_reg;
        asin_next = awrap[13:0];
        acos_sum  = {1'b0, asin_next} + 15'(AngQuad);
        acos_next = (acos_sum >= 15'(AngFull)) ? 14'(acos_sum - 15'(AngFull)) : acos_sum[13:0];
        s1_next.x    = s0_reg.back ? -s0_reg.x : s0_reg.x;
        s1_next.y    = s0_reg.back ? -s0_reg.y : s0_reg.y;
        s1_next.z    = s0_reg.z;
        s1_next.back = s0_reg.back;
    end

    // ---------------------------------------------------------------- stages 2 to 5
    omc_sin u_sin (
        .clk     (clk),
        .en      (en),
        .angle   (asin1_reg),
        .sin_val (sin_v)
    );

    omc_sin u_cos (
        .clk     (clk),
        .en      (en),
        .angle   (acos1_reg),
        .sin_val (cos_v)
    );

    // ---------------------------------------------------------------- stage 6
    // rotation products
    always_comb
    begin
        xc = 32'(rot_reg[3].x) * 32'(cos_v);
        ys = 32'(rot_reg[3].y) * 32'(sin_v);
        xs = 32'(rot_reg[3].x) * 32'(sin_v);
        yc = 32'(rot_reg[3].y) * 32'(cos_v);
    end

    // ---------------------------------------------------------------- stage 8
    // budget: pick divisor, scale factor and the pass-through values
    always_comb
    begin
        ax_next   = 16'(rx7_reg < 0 ? -rx7_reg : rx7_reg);
        ay_next   = 16'(ry7_reg < 0 ? -ry7_reg : ry7_reg);
        az_next   = 15'(z7_reg < 0 ? -z7_reg : z7_reg);
        xy        = 17'(ax_next) + 17'(ay_next);
        total     = xy + 17'(az_next);
        rem_trans = 15'(17'(PctFull) - xy);
        rem_rot   = 15'(PctFull) - az_next;

        side8_next.x      = rx7_reg;
        side8_next.y      = ry7_reg;
        side8_next.z      = 17'(z7_reg);
        side8_next.div_xy = 1'b0;
        side8_next.div_z  = 1'b0;
        side8_next.back   = back7_reg;
        den_next          = xy;
        mul_next          = 15'(PctFull);

        if (total > 17'(PctFull))
        begin
            unique case (mode_t'(mode_reg))
                MODE_FAIR:
                begin
                    side8_next.div_xy = 1'b1;
                    side8_next.div_z  = 1'b1;
                    den_next          = total;
                end
                MODE_TRANS:
                begin
                    if (xy > 17'(PctFull))
                    begin
                        side8_next.div_xy = 1'b1;
                        side8_next.z      = 17'sd0;
                    end
                    else if (az_next > rem_trans)
                    begin
                        side8_next.z = z7_reg < 0 ? -$signed({2'b00, rem_trans})
                                                  : $signed({2'b00, rem_trans});
                    end
                end
                MODE_ROT:
                begin
                    if (xy > 17'(rem_rot))
                    begin
                        side8_next.div_xy = 1'b1;
                        mul_next          = rem_rot;
                    end
                end
                MODE_NONE: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 10 to 24
    omc_div u_div (
        .clk (clk),
        .en  (en),
        .num (num9_reg),
        .den (den9_reg),
        .quo (quo)
    );

    // ---------------------------------------------------------------- stage 25
    // signed quotients back in, wheel mix
    always_comb
    begin
        xf = side_dv_reg[QW-1].div_xy ? apply_sign(side_dv_reg[QW-1].x < 0, quo[0])
                                      : side_dv_reg[QW-1].x;
        yf = side_dv_reg[QW-1].div_xy ? apply_sign(side_dv_reg[QW-1].y < 0, quo[1])
                                      : side_dv_reg[QW-1].y;
        zf = side_dv_reg[QW-1].div_z  ? apply_sign(side_dv_reg[QW-1].z < 0, quo[2])
                                      : side_dv_reg[QW-1].z;
        w_next[0] =  19'(xf) + 19'(yf) - 19'(zf);
        w_next[1] =  19'(xf) - 19'(yf) - 19'(zf);
        w_next[2] = -19'(xf) + 19'(yf) - 19'(zf);
        w_next[3] = -19'(xf) - 19'(yf) - 19'(zf);
    end

    // ---------------------------------------------------------------- output stage
    // divide by 100 by reciprocal, saturate, restore sign
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [44:0] prod;
            logic [15:0] res;
            prod = 45'(t27_reg[k]) * 45'd5368710;
            res  = sat27_reg[k] ? 16'd32767 : prod[44:29];
            whl_next[k] = neg27_reg[k] ? -$signed(res) : $signed(res);
        end
    end

    // ---------------------------------------------------------------- payload pipe
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= s0_next;
            araw0_reg <= araw_next;

            s1_reg    <= s1_next;
            asin1_reg <= asin_next;
            acos1_reg <= acos_next;

            rot_reg[0] <= s1_reg;
            for (int k = 1; k < 4; k++)
            begin
                rot_reg[k] <= rot_reg[k-1];
            end

            px6_reg   <= xc - ys;
            py6_reg   <= xs + yc;
            z6_reg    <= rot_reg[3].z;
            back6_reg <= rot_reg[3].back;

            rx7_reg   <= round_q14(px6_reg);
            ry7_reg   <= round_q14(py6_reg);
            z7_reg    <= z6_reg;
            back7_reg <= back6_reg;

            side8_reg <= side8_next;
            ax8_reg   <= ax_next;
            ay8_reg   <= ay_next;
            az8_reg   <= az_next;
            den8_reg  <= den_next;
            mul8_reg  <= mul_next;

            // dividends already carry the half-divisor for rounding
            side9_reg   <= side8_reg;
            num9_reg[0] <= NW'(ax8_reg) * NW'(mul8_reg) + NW'(den8_reg >> 1);
            num9_reg[1] <= NW'(ay8_reg) * NW'(mul8_reg) + NW'(den8_reg >> 1);
            num9_reg[2] <= NW'(az8_reg) * NW'(mul8_reg) + NW'(den8_reg >> 1);
            den9_reg    <= den8_reg;

            side_dv_reg[0] <= side9_reg;
            for (int j = 1; j < QW; j++)
            begin
                side_dv_reg[j] <= side_dv_reg[j-1];
            end

            for (int k = 0; k < 4; k++)
            begin
                w25_reg[k] <= w_next[k];
            end
            back25_reg <= side_dv_reg[QW-1].back;

            // rpm scaling, then round and drop the Q7.8 percent scale by 256
            for (int k = 0; k < 4; k++)
            begin
                m26_reg[k]   <= 33'(w25_reg[k] < 0 ? -w25_reg[k] : w25_reg[k]) * 33'(rpm_reg);
                neg26_reg[k] <= w25_reg[k] < 0;
            end
            back26_reg <= back25_reg;

            for (int k = 0; k < 4; k++)
            begin
                logic [32:0] ts;
                ts = (m26_reg[k] + 33'd12800) >> 8;
                t27_reg[k]   <= ts[21:0];
                sat27_reg[k] <= ts >= 33'd3276800;
            end
            neg27_reg  <= neg26_reg;
            back27_reg <= back26_reg;
        end
    end

    // ---------------------------------------------------------------- output and skid
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_whl_reg  <= skid_whl_reg;
                out_back_reg <= skid_back_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !wheel.ready)
            begin
                skid_whl_reg  <= whl_next;
                skid_back_reg <= back27_reg;
            end
            else
            begin
                out_whl_reg  <= whl_next;
                out_back_reg <= back27_reg;
            end
        end
    end

    assign wheel.valid             = out_valid_reg;
    assign wheel.wheel_front_left  = out_whl_reg[0];
    assign wheel.wheel_front_right = out_whl_reg[1];
    assign wheel.wheel_rear_left   = out_whl_reg[2];
    assign wheel.wheel_rear_right  = out_whl_reg[3];
    assign wheel.heading_backward  = out_back_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with no output word");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (arrive && out_valid_reg && !wheel.ready) |=> skid_valid_reg)
        else $error("finished word dropped while output stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && wheel.ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid word not moved to output");

    a_wheel_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_whl_reg[0] != -16'sd32768 && out_whl_reg[1] != -16'sd32768 &&
                           out_whl_reg[2] != -16'sd32768 && out_whl_reg[3] != -16'sd32768))
        else $error("wheel setpoint outside saturation range");
`endif

endmodule

`default_nettype wire

// ===== bench/omc_wheel_scoreboard.sv =====
// wheel setpoint scoreboard: expected-word store and comparison for the velocity mixer bench
`timescale 1ns / 100ps

package omc_sb_pkg;

    typedef struct packed {
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] rl;
        logic signed [15:0] rr;
        logic               back;
    } wheel_word_t;

    class omc_wheel_scoreboard;
        wheel_word_t pending_wheels[$];
        int          mismatch_cnt;

        function new();
            mismatch_cnt = 0;
        endfunction

        function void note_command(wheel_word_t w);
            pending_wheels.push_back(w);
        endfunction

        function void check_wheels(wheel_word_t got);
            wheel_word_t exp_w;
            if (pending_wheels.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected wheel word %h", got);
                return;
            end
            exp_w = pending_wheels.pop_front();
            if (exp_w !== got)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display({"wheel mismatch: exp fl=%0d fr=%0d rl=%0d rr=%0d b=%0d",
                              " got fl=%0d fr=%0d rl=%0d rr=%0d b=%0d"},
                             exp_w.fl, exp_w.fr, exp_w.rl, exp_w.rr, exp_w.back,
                             got.fl, got.fr, got.rl, got.rr, got.back);
            end
        endfunction
    endclass

endpackage

// ===== bench/tb.sv =====
// top-level bench for the omni chassis velocity mixer
`timescale 1ns / 100ps

module tb;
    import omc_pkg::*;
    import omc_sb_pkg::*;

    logic clk;
    logic rst_n;

    omc_cmd_if cmd();
    omc_whl_if wheel();
    omc_cfg_if cfg();

    omni_chassis_velocity_mixer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .wheel (wheel.source),
        .cfg   (cfg.sink)
    );

    omc_wheel_scoreboard board;

    // local copy of the mixer registers
    int unsigned mix_mode;
    int unsigned mix_rpm;
    int unsigned mix_origin;

    // sine table at 5 degree steps, Q2.14
    const int sine_pts[19] = '{0, 1428, 2845, 4240, 5604, 6924, 8192, 9397, 10531, 11585,
                               12551, 13421, 14189, 14849, 15396, 15826, 16135, 16322, 16384};

    bit stall_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // safety net against a hung handshake
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // round to nearest, half away from zero
    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // sine over the first quadrant, interpolated between table points
    function automatic int quad_sine(int r);
        int i;
        int f;
        i = r / 225;
        f = r % 225;
        if (i >= 18)
            return 16384;
        return sine_pts[i] + ((sine_pts[i + 1] - sine_pts[i]) * f + 112) / 225;
    endfunction

    function automatic int sine_q14(int a);
        int q;
        int r;
        q = a / AngQuad;
        r = a % AngQuad;
        case (q & 3)
            0: return quad_sine(r);
            1: return quad_sine(AngQuad - r);
            2: return -quad_sine(r);
            default: return -quad_sine(AngQuad - r);
        endcase
    endfunction

    function automatic longint axis_limit(longint v);
        if (v > 0) return PctFull;
        if (v < 0) return -PctFull;
        return 0;
    endfunction

    function automatic logic [15:0] rpm_scale(longint w);
        longint r;
        r = round_div(w * longint'(mix_rpm), PctFull);
        if (r > 32767) r = 32767;
        if (r < -32767) r = -32767;
        return r[15:0];
    endfunction

    // expected wheel word for one command
    function automatic wheel_word_t mix_wheels(
        logic signed [15:0] sx, logic signed [15:0] sy, logic signed [15:0] sz,
        logic [12:0] cnt_raw);
        wheel_word_t w;
        longint x, y, z, rx, ry, xy, total, remain;
        int cnt, a, s, c;
        bit back;
        x = sx;
        y = sy;
        z = sz;
        cnt = cnt_raw;
        back = (cnt > 2025) && (cnt < 6075);
        // any axis beyond full scale pins all axes
        if (mag_of(x) > PctFull || mag_of(y) > PctFull || mag_of(z) > PctFull)
        begin
            x = axis_limit(x);
            y = axis_limit(y);
            z = axis_limit(z);
        end
        a = 2 * cnt - (back ? AngHalf : 0) - 45 * int'(mix_origin);
        a = a % AngFull;
        if (a < 0) a += AngFull;
        s = sine_q14(a);
        c = sine_q14((a + AngQuad) % AngFull);
        if (back)
        begin
            x = -x;
            y = -y;
        end
        rx = round_div(x * c - y * s, 16384);
        ry = round_div(x * s + y * c, 16384);
        x = rx;
        y = ry;
        xy = mag_of(x) + mag_of(y);
        total = xy + mag_of(z);
        if (total > PctFull)
        begin
            if (mix_mode == MODE_FAIR)
            begin
                x = round_div(x * PctFull, total);
                y = round_div(y * PctFull, total);
                z = round_div(z * PctFull, total);
            end
            else if (mix_mode == MODE_TRANS)
            begin
                remain = PctFull - xy;
                if (remain < 0)
                begin
                    x = round_div(x * PctFull, xy);
                    y = round_div(y * PctFull, xy);
                    z = 0;
                end
                else if (mag_of(z) > remain)
                    z = (z < 0) ? -remain : remain;
            end
            else if (mix_mode == MODE_ROT)
            begin
                remain = PctFull - mag_of(z);
                if (xy > remain)
                begin
                    x = round_div(x * remain, xy);
                    y = round_div(y * remain, xy);
                end
            end
        end
        w.fl = rpm_scale(x + y - z);
        w.fr = rpm_scale(x - y - z);
        w.rl = rpm_scale(-x + y - z);
        w.rr = rpm_scale(-x - y - z);
        w.back = back;
        return w;
    endfunction

    // register write, block must be idle
    task automatic write_reg(reg_idx_t idx, int unsigned val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val[14:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_MODE:   mix_mode   = val & 3;
            REG_RPM:    mix_rpm    = val & 32'h7fff;
            REG_ORIGIN: mix_origin = val & 32'h1ff;
            default: ;
        endcase
    endtask

    // one command word; valid stays high across back-to-back words
    task automatic send_command(logic signed [15:0] sx, logic signed [15:0] sy,
                                logic signed [15:0] sz, logic [12:0] cnt);
        cmd.valid        <= 1'b1;
        cmd.set_x        <= sx;
        cmd.set_y        <= sy;
        cmd.set_z        <= sz;
        cmd.gimbal_angle <= cnt;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        board.note_command(mix_wheels(sx, sy, sz, cnt));
    endtask

    task automatic idle_sender(int n);
        cmd.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait until every expected word is back, then let the pipe drain
    task automatic drain_wheels();
        cmd.valid <= 1'b0;
        while (board.pending_wheels.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);                                // full range
            1: return 16'($urandom_range(0, 4) * 6400 - 12800);     // round percents
            2: return 16'((16'sd1 <<< $urandom_range(0, 14)) *
                          ($urandom_range(0, 1) ? 1 : -1));
            default: return $signed(16'($urandom_range(0, 51200))) - 16'sd25600;
        endcase
    endfunction

    task automatic random_burst(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            send_command(pick_axis(), pick_axis(), pick_axis(), 13'($urandom));
            // bursts with random gaps between them
            if ($urandom_range(0, 9) == 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    // result side: check accepted words, stall on its own pattern
    always @(posedge clk)
    begin
        if (rst_n && wheel.valid && wheel.ready)
            board.check_wheels({wheel.wheel_front_left, wheel.wheel_front_right,
                                wheel.wheel_rear_left, wheel.wheel_rear_right,
                                wheel.heading_backward});
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel.ready <= 1'b0;
        else if (stall_on)
            wheel.ready <= ($urandom_range(0, 3) != 0);
        else
            wheel.ready <= 1'b1;
    end

    int phase;
    int sweep;

    initial
    begin
        board = new();
        mix_mode = 0;
        mix_rpm = 8000;
        mix_origin = 0;
        stall_on = 1'b0;
        cmd.valid = 1'b0;
        cmd.set_x = '0;
        cmd.set_y = '0;
        cmd.set_z = '0;
        cmd.gimbal_angle = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_MODE;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes and heading boundaries
        send_command(16'sd0, 16'sd0, 16'sd0, 13'd0);
        send_command(16'sd25600, 16'sd0, 16'sd0, 13'd0);           // full forward
        send_command(16'sd10000, 16'sd5000, 16'sd3000, 13'd1000);   // within budget
        send_command(-16'sd32768, 16'sd0, 16'sd32767, 13'd0);       // axis over range
        send_command(16'sd32767, 16'sd32767, 16'sd32767, 13'd8191); // count wraps past 8100
        send_command(16'sd20000, -16'sd20000, 16'sd20000, 13'd2025);
        send_command(16'sd20000, -16'sd20000, 16'sd20000, 13'd2026);// backward edge
        send_command(16'sd20000, 16'sd1000, -16'sd5000, 13'd6074);
        send_command(16'sd20000, 16'sd1000, -16'sd5000, 13'd6075);
        send_command(-16'sd1, 16'sd1, -16'sd1, 13'd8100);
        send_command(16'sd25601, 16'sd0, 16'sd0, 13'd4050);
        drain_wheels();

        // every mode, including the no-budget mode, with extreme rpm and origin
        for (phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_MODE, phase);
            for (sweep = 0; sweep < 3; sweep++)
            begin
                case (sweep)
                    0: write_reg(REG_RPM, 32767);
                    1: write_reg(REG_RPM, 0);
                    default: write_reg(REG_RPM, $urandom_range(0, 32767));
                endcase
                write_reg(REG_ORIGIN, (sweep == 0) ? 359 : (sweep == 1) ? 0 : 511);
                send_command(16'sd25600, 16'sd25600, 16'sd0, 13'd900);
                send_command(16'sd12800, 16'sd12800, 16'sd25600, 13'd3000); // full z
                send_command(16'sd20000, 16'sd10000, -16'sd10000, 13'd5000);
                drain_wheels();
            end
        end

        // random phases over random settings, receiver stalls on half of them
        for (phase = 0; phase < 12; phase++)
        begin
            stall_on = phase[0];
            write_reg(REG_MODE, $urandom_range(0, 3));
            write_reg(REG_RPM, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
                                                           : $urandom_range(1000, 12000));
            write_reg(REG_ORIGIN, $urandom_range(0, 511));
            random_burst(50);
            // hold off until the pipe is empty, then continue in the same setting
            while (board.pending_wheels.size() != 0)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
            end
            random_burst(50);
            drain_wheels();
        end

        stall_on = 1'b0;
        drain_wheels();
        if (board.mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/omc_pkg.sv
rtl/omc_if.sv
rtl/omc_sin.sv
rtl/omc_div.sv
rtl/omni_chassis_velocity_mixer.sv
bench/omc_wheel_scoreboard.sv
bench/tb.sv
